### rtl/core/wfba_pkg.sv
// Package for the worst-fit block allocator: sizes, codes, control word and microcode ROM.
package wfba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);

  // Port widths fixed by the interface
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OUT_IDX_W = 4;
  localparam int IN_SIZE_W = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam int UPC_BITS = 3;

  // Microprogram addresses
  localparam logic [UPC_BITS-1:0] UPC_IDLE     = 3'd0;
  localparam logic [UPC_BITS-1:0] UPC_DISPATCH = 3'd1;
  localparam logic [UPC_BITS-1:0] UPC_CLEAR    = 3'd2;
  localparam logic [UPC_BITS-1:0] UPC_APPEND   = 3'd3;
  localparam logic [UPC_BITS-1:0] UPC_SCAN     = 3'd4;
  localparam logic [UPC_BITS-1:0] UPC_ALLOC_WB = 3'd5;
  localparam logic [UPC_BITS-1:0] UPC_OTHER    = 3'd6;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LATCH,
    DP_SCAN_INIT,
    DP_CLEAR,
    DP_APPEND,
    DP_SCAN,
    DP_ALLOC_END,
    DP_EMIT_ZERO
  } dp_op_t;

  typedef enum logic [1:0] {
    SEQ_WAIT_START,  // hold until a request arrives, then fall through
    SEQ_DISPATCH,    // multiway branch on the latched command
    SEQ_LOOP_SCAN,   // stay at target while reads remain to issue
    SEQ_JUMP         // unconditional jump to target
  } seq_op_t;

  typedef struct packed {
    logic                busy;
    dp_op_t              dp;
    seq_op_t             seq;
    logic [UPC_BITS-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_BITS-1:0] upc);
    ucode_t w;
    w = '{busy: 1'b1, dp: DP_NONE, seq: SEQ_JUMP, target: UPC_IDLE};
    unique case (upc)
      UPC_IDLE:     w = '{busy: 1'b0, dp: DP_LATCH,     seq: SEQ_WAIT_START, target: UPC_IDLE};
      UPC_DISPATCH: w = '{busy: 1'b1, dp: DP_SCAN_INIT, seq: SEQ_DISPATCH,   target: UPC_IDLE};
      UPC_CLEAR:    w = '{busy: 1'b1, dp: DP_CLEAR,     seq: SEQ_JUMP,       target: UPC_IDLE};
      UPC_APPEND:   w = '{busy: 1'b1, dp: DP_APPEND,    seq: SEQ_JUMP,       target: UPC_IDLE};
      UPC_SCAN:     w = '{busy: 1'b1, dp: DP_SCAN,      seq: SEQ_LOOP_SCAN,  target: UPC_SCAN};
      UPC_ALLOC_WB: w = '{busy: 1'b1, dp: DP_ALLOC_END, seq: SEQ_JUMP,       target: UPC_IDLE};
      UPC_OTHER:    w = '{busy: 1'b1, dp: DP_EMIT_ZERO, seq: SEQ_JUMP,       target: UPC_IDLE};
      default:      w = '{busy: 1'b1, dp: DP_NONE,      seq: SEQ_JUMP,       target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/worst_fit_block_allocator.sv
// Worst-fit block allocator: microcoded sequencer over a free-size table.
//
// Usage: drive cmd and size_value with start high; the request is taken at a
// rising edge where start is high and busy is low. Commands: clear table,
// append one block size, allocate a request. Every request yields exactly one
// result on status, slot_index and size_left, marked by done for a single
// cycle. The receiver cannot stall; a result is valid only in its done cycle.
//
// Clear, append and the unused command pass through the dispatch step and
// then their own step. The allocate time is set by the scan: one table
// read and one compare per block through a single registered memory read
// port and the hit comparison, plus dispatch and write-back steps. busy
// drops in the cycle done is shown, so the next request can be taken
// there; a new request is not taken before the result of the last.
//
// Reset clears the step counter and the loaded-block count; the size table
// itself is not cleared and entries beyond the count are never compared.
module worst_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [wfba_pkg::CMD_W-1:0]     cmd,
  input  logic [wfba_pkg::IN_SIZE_W-1:0] size_value,
  output logic                           done,
  output logic [wfba_pkg::STATUS_W-1:0]  status,
  output logic [wfba_pkg::OUT_IDX_W-1:0] slot_index,
  output logic [wfba_pkg::IN_SIZE_W-1:0] size_left
);
  import wfba_pkg::*;

  logic [SIZE_BITS-1:0] free_sizes [MAX_BLOCKS];

  logic [UPC_BITS-1:0]  upc;
  logic [UPC_BITS-1:0]  upc_next;
  ucode_t               uw;

  logic [CMD_W-1:0]     cmd_r;
  logic [SIZE_BITS-1:0] val_r;
  logic [CNT_BITS-1:0]  blocks_loaded;
  logic [CNT_BITS-1:0]  scan_cnt;
  logic [SIZE_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 rd_valid;
  logic [SIZE_BITS-1:0] best;
  logic [IDX_BITS-1:0]  pick;
  logic                 found;

  logic                 scan_more;
  logic                 table_full;
  logic                 hit;
  logic [SIZE_BITS-1:0] remain;
  logic                 mem_we;
  logic [IDX_BITS-1:0]  mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  assign uw         = ucode_rom(upc);
  assign busy       = uw.busy;
  assign scan_more  = (scan_cnt < blocks_loaded);
  assign table_full = (blocks_loaded == CNT_BITS'(MAX_BLOCKS));
  assign hit        = rd_valid && (rd_data >= val_r) && (rd_data > best);
  assign remain     = best - val_r;

  // Sequencer
  always_comb begin
    upc_next = upc + UPC_BITS'(1);
    unique case (uw.seq)
      SEQ_WAIT_START: begin
        if (!start) upc_next = upc;
      end
      SEQ_DISPATCH: begin
        unique case (cmd_r)
          CMD_CLEAR:  upc_next = UPC_CLEAR;
          CMD_APPEND: upc_next = UPC_APPEND;
          CMD_ALLOC:  upc_next = UPC_SCAN;
          default:    upc_next = UPC_OTHER;
        endcase
      end
      SEQ_LOOP_SCAN: begin
        if (scan_more) upc_next = uw.target;
      end
      SEQ_JUMP: upc_next = uw.target;
      default:  upc_next = UPC_IDLE;
    endcase
  end

  // Single write port: append writes the next slot, allocate writes back the pick
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick;
    mem_wdata = remain;
    if (uw.dp == DP_APPEND && !table_full) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_BITS'(blocks_loaded);
      mem_wdata = val_r;
    end else if (uw.dp == DP_ALLOC_END && found) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) free_sizes[mem_waddr] <= mem_wdata;
    rd_data <= free_sizes[IDX_BITS'(scan_cnt)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc           <= UPC_IDLE;
      blocks_loaded <= '0;
      done          <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      upc  <= upc_next;
      done <= 1'b0;
      unique case (uw.dp)
        DP_LATCH: begin
          if (start) begin
            cmd_r <= cmd;
            val_r <= SIZE_BITS'(size_value);
          end
        end
        DP_SCAN_INIT: begin
          scan_cnt <= '0;
          best     <= '0;
          pick     <= '0;
          found    <= 1'b0;
          rd_valid <= 1'b0;
        end
        DP_CLEAR: begin
          blocks_loaded <= '0;
          done          <= 1'b1;
          status        <= ST_DONE;
          slot_index    <= '0;
          size_left     <= '0;
        end
        DP_APPEND: begin
          done <= 1'b1;
          if (table_full) begin
            status     <= ST_FULL;
            slot_index <= '0;
            size_left  <= '0;
          end else begin
            blocks_loaded <= blocks_loaded + CNT_BITS'(1);
            status        <= ST_DONE;
            slot_index    <= OUT_IDX_W'(blocks_loaded);
            size_left     <= IN_SIZE_W'(val_r);
          end
        end
        DP_SCAN: begin
          // read issued here is compared on the following step
          rd_valid <= scan_more;
          rd_idx   <= IDX_BITS'(scan_cnt);
          if (scan_more) scan_cnt <= scan_cnt + CNT_BITS'(1);
          if (hit) begin
            best  <= rd_data;
            pick  <= rd_idx;
            found <= 1'b1;
          end
        end
        DP_ALLOC_END: begin
          done     <= 1'b1;
          rd_valid <= 1'b0;
          if (found) begin
            status     <= ST_DONE;
            slot_index <= OUT_IDX_W'(pick);
            size_left  <= IN_SIZE_W'(remain);
          end else begin
            status     <= ST_NOFIT;
            slot_index <= '0;
            size_left  <= '0;
          end
        end
        DP_EMIT_ZERO: begin
          done       <= 1'b1;
          status     <= ST_DONE;
          slot_index <= '0;
          size_left  <= '0;
        end
        default: ;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    blocks_loaded <= CNT_BITS'(MAX_BLOCKS))
    else $error("loaded block count beyond capacity");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but sequencer did not leave idle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> table_full)
    else $error("full status reported with free slots");

  a_scan_leaves_idle_count: assert property (@(posedge clk) disable iff (rst)
    upc == UPC_ALLOC_WB |-> !scan_more && !rd_valid)
    else $error("write-back step reached with scan unfinished");

endmodule

### test/worst_fit_block_allocator_tb.sv
// Self-checking testbench for the worst-fit block allocator: directed and random requests against a predictor.
module worst_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wfba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DIRECTED_REQS = 25;
  localparam int TOTAL_REQS    = DIRECTED_REQS + 410;
  localparam int CALM_TAIL     = 60;
  localparam int STALL_LIMIT   = 500;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] slot_index;
    logic [IN_SIZE_W-1:0] size_left;
  } alloc_result_t;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [IN_SIZE_W-1:0] size_value;
    int                   gap;
    bit                   drain;
  } alloc_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [CMD_W-1:0]      cmd = CMD_CLEAR;
  logic [IN_SIZE_W-1:0]  size_value = '0;
  logic                  busy;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [OUT_IDX_W-1:0]  slot_index;
  logic [IN_SIZE_W-1:0]  size_left;

  alloc_req_t    pending_reqs[$];
  alloc_result_t results_due[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            hold_cycles = 0;
  int            reqs_queued = 0;

  // shadow copy of the free-size table
  logic [SIZE_BITS-1:0] shadow_sizes[MAX_BLOCKS];
  int                   shadow_loaded = 0;

  worst_fit_block_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .size_value  (size_value),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index),
    .size_left   (size_left)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic alloc_result_t predict_request(logic [CMD_W-1:0] c,
                                                    logic [IN_SIZE_W-1:0] v);
    alloc_result_t        r;
    logic [SIZE_BITS-1:0] best;
    int                   pick;
    bit                   found;
    r = '{status: ST_DONE, slot_index: '0, size_left: '0};
    best = '0;
    pick = 0;
    found = 1'b0;
    case (c)
      CMD_CLEAR: shadow_loaded = 0;
      CMD_APPEND: begin
        if (shadow_loaded >= MAX_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          shadow_sizes[shadow_loaded] = v;
          r.slot_index = shadow_loaded[OUT_IDX_W-1:0];
          r.size_left = v;
          shadow_loaded++;
        end
      end
      CMD_ALLOC: begin
        // strict > keeps the lowest index on ties and skips empty blocks
        for (int j = 0; j < shadow_loaded; j++) begin
          if (shadow_sizes[j] >= v && shadow_sizes[j] > best) begin
            best = shadow_sizes[j];
            pick = j;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NOFIT;
        end else begin
          shadow_sizes[pick] = best - v;
          r.slot_index = pick[OUT_IDX_W-1:0];
          r.size_left = best - v;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(predict_request(cmd, size_value));
      end
      if (!start || !busy) begin
        if (hold_cycles > 0) begin
          hold_cycles <= hold_cycles - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0 && pending_reqs[0].gap > 0) begin
          hold_cycles <= pending_reqs[0].gap - 1;
          pending_reqs[0].gap = 0;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain || results_due.size() == 0)) begin
          start <= 1'b1;
          cmd <= pending_reqs[0].cmd;
          size_value <= pending_reqs[0].size_value;
          void'(pending_reqs.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot_index=%0d size_left=%0d",
                 $time, status, slot_index, size_left);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          mismatches++;
        end
        if (slot_index !== want.slot_index) begin
          $display("%0t: slot_index expected %0d actual %0d",
                   $time, want.slot_index, slot_index);
          mismatches++;
        end
        if (size_left !== want.size_left) begin
          $display("%0t: size_left expected %0d actual %0d",
                   $time, want.size_left, size_left);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_req(logic [CMD_W-1:0] c, logic [IN_SIZE_W-1:0] v, int gap,
                           bit drain);
    pending_reqs.push_back('{cmd: c, size_value: v, gap: gap, drain: drain});
    reqs_queued++;
  endtask

  function automatic logic [IN_SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return IN_SIZE_W'($urandom_range(1, 255));
      default: return IN_SIZE_W'($urandom());
    endcase
  endfunction

  function automatic int pick_gap(bit idling_on);
    if (!idling_on || reqs_queued >= TOTAL_REQS - CALM_TAIL) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 11);
    return 0;
  endfunction

  initial begin
    int                   nblk;
    int                   nalloc;
    int                   loaded;
    int                   want;
    bit                   idling_on;
    bit                   first;
    logic [IN_SIZE_W-1:0] sz;
    int                   appended[MAX_BLOCKS];

    // directed: empty table, unused command, zero blocks, ties, full table
    queue_req(CMD_ALLOC, 16'd5, 0, 1'b0);
    queue_req(CMD_UNUSED, 16'hFFFF, 0, 1'b0);
    queue_req(CMD_APPEND, 16'd0, 2, 1'b0);
    queue_req(CMD_ALLOC, 16'd0, 0, 1'b0);
    queue_req(CMD_APPEND, 16'hFFFF, 0, 1'b0);
    queue_req(CMD_APPEND, 16'd100, 0, 1'b0);
    queue_req(CMD_APPEND, 16'hFFFF, 0, 1'b0);
    queue_req(CMD_ALLOC, 16'd0, 0, 1'b0);
    queue_req(CMD_ALLOC, 16'hFFFF, 3, 1'b0);
    queue_req(CMD_ALLOC, 16'hFFFF, 0, 1'b0);
    queue_req(CMD_ALLOC, 16'd101, 0, 1'b0);
    for (int k = 4; k < MAX_BLOCKS; k++) begin
      queue_req(CMD_APPEND, IN_SIZE_W'(16'h5555 << (k % 2)), 0, 1'b0);
    end
    queue_req(CMD_APPEND, 16'hFFFF, 0, 1'b0);
    queue_req(CMD_CLEAR, 16'hFFFF, 0, 1'b0);

    // random episodes: usually a clear, then load a table, then a run of allocations and unused commands
    first = 1'b1;
    loaded = 0;
    while (reqs_queued < TOTAL_REQS) begin
      idling_on = ($urandom_range(0, 2) != 0);
      if (first || $urandom_range(0, 7) != 0) begin
        // no draining pauses in the calm tail
        queue_req(CMD_CLEAR, IN_SIZE_W'($urandom()), pick_gap(idling_on),
                  first || ($urandom_range(0, 3) == 0 &&
                            reqs_queued < TOTAL_REQS - CALM_TAIL));
        loaded = 0;
      end
      first = 1'b0;
      nblk = $urandom_range(1, MAX_BLOCKS);
      if ($urandom_range(0, 4) == 0) nblk = MAX_BLOCKS + $urandom_range(1, 3);
      for (int k = 0; k < nblk; k++) begin
        sz = pick_size();
        if (loaded < MAX_BLOCKS) begin
          appended[loaded] = sz;
          loaded++;
        end
        queue_req(CMD_APPEND, sz, pick_gap(idling_on), 1'b0);
      end
      nalloc = $urandom_range(2, 10);
      for (int k = 0; k < nalloc; k++) begin
        case ($urandom_range(0, 11))
          0: queue_req(CMD_UNUSED, IN_SIZE_W'($urandom()), pick_gap(idling_on), 1'b0);
          1: queue_req(CMD_ALLOC, '0, pick_gap(idling_on), 1'b0);
          2, 3: queue_req(CMD_ALLOC, pick_size(), pick_gap(idling_on), 1'b0);
          default: begin
            // request sized against a loaded block so most requests fit
            want = (loaded > 0) ? appended[$urandom_range(0, loaded - 1)] : 0;
            queue_req(CMD_ALLOC, IN_SIZE_W'($urandom_range(0, want)),
                      pick_gap(idling_on), 1'b0);
          end
        endcase
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_reqs.size() == 0 && !start && results_due.size() == 0)) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
